// ===== design/wdfb_pkg.sv =====
package wdfb_pkg;

    localparam int ADDR_W     = 6;
    localparam int DATA_W     = 64;
    localparam int MAC_W      = 48;
    localparam int SEQ_W      = 12;
    localparam int HDR_BYTES  = 24;
    localparam int FCS_BYTES  = 4;

    localparam logic [7:0]  FRAME_CTRL_LO = 8'h08;
    localparam logic [7:0]  FRAME_CTRL_HI = 8'h00;
    localparam logic [15:0] DURATION      = 16'h0000;
    localparam logic [31:0] CRC_POLY      = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT      = 32'hFFFF_FFFF;

    // register index = paddr[5:3]
    localparam logic [2:0] REG_DEST   = 3'd0;
    localparam logic [2:0] REG_SOURCE = 3'd1;
    localparam logic [2:0] REG_BSS    = 3'd2;
    localparam logic [2:0] REG_SEQ    = 3'd3;
    localparam logic [2:0] REG_FCS    = 3'd4;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       last_byte;
        logic       empty_frame;
    } in_item_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_last;
        logic       oversize;
    } out_item_t;

    typedef enum logic [1:0] {
        PH_HDR,
        PH_PAY,
        PH_FCS
    } phase_t;

    // reflected CRC-32, one byte
    function automatic logic [31:0] crc_update(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'h0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== design/wlan_data_frame_builder_core.sv =====
// 802.11 data frame builder. Each s_ transfer carries one payload byte (or an
// empty-frame request); m_ transfers carry the built frame one byte at a time.
// The first input of a frame holds the input side while the 24-byte header
// goes out, then its payload byte follows; the last input adds the 4-byte FCS
// when append_fcs is set. A payload byte beyond MAX_PAYLOAD is dropped with
// no output. One byte sequencer feeds an output register; the next input is
// taken on the step that finishes the current one, or while a finished byte
// waits on m_ready once the sequencer holds no item.
// Registers (APB, 64-bit data, register i at byte 8*i): dest_address,
// source_address, bss_address, sequence_number, append_fcs (reset 1).
module wlan_data_frame_builder_core #(
    parameter int MAX_PAYLOAD = 1500
) (
    input  logic                         aclk,
    input  logic                         aresetn,

    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [wdfb_pkg::ADDR_W-1:0]  paddr,
    input  logic [wdfb_pkg::DATA_W-1:0]  pwdata,
    output logic [wdfb_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,

    input  logic                         s_valid,
    output logic                         s_ready,
    input  wdfb_pkg::in_item_t           s_data,

    output logic                         m_valid,
    input  logic                         m_ready,
    output wdfb_pkg::out_item_t          m_data
);
    import wdfb_pkg::*;

    localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PAYLOAD);
    localparam logic [4:0] HDR_END = 5'(HDR_BYTES - 1);
    localparam logic [4:0] FCS_END = 5'(FCS_BYTES - 1);

    // configuration
    logic [MAC_W-1:0] dest_reg, source_reg, bss_reg;
    logic [SEQ_W-1:0] seq_reg;
    logic             fcs_en_reg;
    logic             cfg_wr;
    logic [2:0]       cfg_idx;

    // sequencer and frame state
    in_item_t         item_reg;
    logic             item_valid_reg, item_valid_next;
    phase_t           phase_reg, phase_next;
    logic [4:0]       idx_reg, idx_next;
    logic             in_frame_reg, in_frame_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [31:0]      crc_reg, crc_next;
    logic             ovf_reg, ovf_next;
    logic             m_valid_reg;
    out_item_t        m_data_reg;

    logic             step, load;
    logic             ending, room, take, drop;
    logic             emit, olast, done, crc_add, clear;
    logic [7:0]       obyte;
    logic [191:0]     hdr_vec;
    logic [31:0]      fcs_vec;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[5:3];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dest_reg   <= '0;
            source_reg <= '0;
            bss_reg    <= '0;
            seq_reg    <= '0;
            fcs_en_reg <= 1'b1;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_DEST:   dest_reg   <= pwdata[MAC_W-1:0];
                REG_SOURCE: source_reg <= pwdata[MAC_W-1:0];
                REG_BSS:    bss_reg    <= pwdata[MAC_W-1:0];
                REG_SEQ:    seq_reg    <= pwdata[SEQ_W-1:0];
                REG_FCS:    fcs_en_reg <= pwdata[0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_DEST:   prdata = {{(DATA_W-MAC_W){1'b0}}, dest_reg};
            REG_SOURCE: prdata = {{(DATA_W-MAC_W){1'b0}}, source_reg};
            REG_BSS:    prdata = {{(DATA_W-MAC_W){1'b0}}, bss_reg};
            REG_SEQ:    prdata = {{(DATA_W-SEQ_W){1'b0}}, seq_reg};
            REG_FCS:    prdata = {{(DATA_W-1){1'b0}}, fcs_en_reg};
            default:    prdata = '0;
        endcase
    end

    // header as sent, first byte in the top bits
    assign hdr_vec = {FRAME_CTRL_LO, FRAME_CTRL_HI, DURATION[7:0], DURATION[15:8],
                      dest_reg, source_reg, bss_reg, seq_reg[3:0], 4'h0, seq_reg[11:4]};
    assign fcs_vec = ~crc_reg;

    assign step   = item_valid_reg && (!m_valid_reg || m_ready);
    assign ending = item_reg.last_byte || item_reg.empty_frame;
    assign room   = count_reg < CNT_MAX;
    assign take   = !item_reg.empty_frame && room;
    assign drop   = !item_reg.empty_frame && !room;

    assign s_ready = !item_valid_reg || (step && done);
    assign load    = s_valid && s_ready;

    // outputs of the sequencer for the current step
    always_comb begin
        emit    = 1'b0;
        olast   = 1'b0;
        done    = 1'b0;
        crc_add = 1'b0;
        clear   = 1'b0;
        obyte   = '0;
        case (phase_reg)
            PH_HDR: begin
                emit    = 1'b1;
                crc_add = 1'b1;
                obyte   = hdr_vec[8*(HDR_END - idx_reg) +: 8];
                if (idx_reg == HDR_END && item_reg.empty_frame && !fcs_en_reg) begin
                    olast = 1'b1;
                    done  = 1'b1;
                    clear = 1'b1;
                end
            end
            PH_PAY: begin
                if (take) begin
                    emit    = 1'b1;
                    crc_add = 1'b1;
                    obyte   = item_reg.payload_byte;
                    if (!ending) begin
                        done = 1'b1;
                    end else if (!fcs_en_reg) begin
                        olast = 1'b1;
                        done  = 1'b1;
                        clear = 1'b1;
                    end
                end else if (!ending) begin
                    done = 1'b1;
                end else if (!fcs_en_reg) begin
                    // frame ends with nothing else to carry the last mark
                    emit  = 1'b1;
                    olast = 1'b1;
                    done  = 1'b1;
                    clear = 1'b1;
                end
            end
            PH_FCS: begin
                emit  = 1'b1;
                obyte = fcs_vec[8*idx_reg[1:0] +: 8];
                if (idx_reg == FCS_END) begin
                    olast = 1'b1;
                    done  = 1'b1;
                    clear = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        in_frame_next = in_frame_reg;
        count_next    = count_reg;
        crc_next      = crc_reg;
        ovf_next      = ovf_reg;
        if (step) begin
            if (phase_reg == PH_HDR) in_frame_next = 1'b1;
            if (phase_reg == PH_PAY && take) count_next = count_reg + 1'b1;
            if (phase_reg == PH_PAY && drop) ovf_next = 1'b1;
            if (crc_add) crc_next = crc_update(crc_reg, obyte);
            if (clear) begin
                in_frame_next = 1'b0;
                count_next    = '0;
                crc_next      = CRC_INIT;
                ovf_next      = 1'b0;
            end
        end
    end

    // next phase, byte index and item valid
    always_comb begin
        phase_next      = phase_reg;
        idx_next        = idx_reg;
        item_valid_next = item_valid_reg;
        if (step && done) item_valid_next = 1'b0;
        if (load) begin
            item_valid_next = 1'b1;
            phase_next      = in_frame_next ? PH_PAY : PH_HDR;
            idx_next        = '0;
        end else if (step && !done) begin
            case (phase_reg)
                PH_HDR: begin
                    if (idx_reg == HDR_END) begin
                        phase_next = item_reg.empty_frame ? PH_FCS : PH_PAY;
                        idx_next   = '0;
                    end else begin
                        idx_next = idx_reg + 5'd1;
                    end
                end
                PH_PAY: begin
                    phase_next = PH_FCS;
                    idx_next   = '0;
                end
                PH_FCS:  idx_next = idx_reg + 5'd1;
                default: phase_next = PH_HDR;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
            phase_reg      <= PH_HDR;
            idx_reg        <= '0;
            in_frame_reg   <= 1'b0;
            count_reg      <= '0;
            crc_reg        <= CRC_INIT;
            ovf_reg        <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            item_valid_reg <= item_valid_next;
            phase_reg      <= phase_next;
            idx_reg        <= idx_next;
            in_frame_reg   <= in_frame_next;
            count_reg      <= count_next;
            crc_reg        <= crc_next;
            ovf_reg        <= ovf_next;
            if (step && emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg <= s_data;
        end
        if (step && emit) begin
            m_data_reg.frame_byte <= obyte;
            m_data_reg.frame_last <= olast;
            m_data_reg.oversize   <= ovf_reg || (phase_reg == PH_PAY && drop);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== design/wdfb_checker.sv =====
module wdfb_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input wdfb_pkg::in_item_t  s_data,
    input logic                m_valid,
    input logic                m_ready,
    input wdfb_pkg::out_item_t m_data
);
    import wdfb_pkg::*;

    logic [4:0] pos_reg;      // bytes of the current frame already transferred, saturating
    logic       ovs_seen_reg; // an oversize byte went out earlier in this frame
    logic       m_xfer;

    assign m_xfer = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            ovs_seen_reg <= 1'b0;
        end else if (m_xfer) begin
            if (m_data.frame_last) begin
                pos_reg      <= '0;
                ovs_seen_reg <= 1'b0;
            end else begin
                if (pos_reg != 5'(HDR_BYTES)) pos_reg <= pos_reg + 5'd1;
                if (m_data.oversize) ovs_seen_reg <= 1'b1;
            end
        end
    end

    a_s_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("input transfer changed while waiting");

    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_frame_start: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && pos_reg == 5'd0 |-> m_data.frame_byte == FRAME_CTRL_LO && !m_data.oversize)
        else $error("frame does not open with frame control");

    a_min_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.frame_last |-> pos_reg >= 5'(HDR_BYTES - 1))
        else $error("frame shorter than header");

    a_oversize_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && ovs_seen_reg |-> m_data.oversize)
        else $error("oversize dropped within a frame");

endmodule

bind wlan_data_frame_builder_core wdfb_checker u_wdfb_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ===== dv/wdfb_frame_checker.sv =====
module wdfb_frame_checker #(
    parameter int PAYLOAD_LIMIT = 1500
) (
    input  logic                        aclk,
    input  logic                        aresetn,

    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic                        pready,
    input  logic [wdfb_pkg::ADDR_W-1:0] paddr,
    input  logic [wdfb_pkg::DATA_W-1:0] pwdata,

    input  logic                        s_valid,
    input  logic                        s_ready,
    input  wdfb_pkg::in_item_t          s_data,

    input  logic                        m_valid,
    input  logic                        m_ready,
    input  wdfb_pkg::out_item_t         m_data,

    output int                          mismatch_count,
    output int                          results_pending
);
    import wdfb_pkg::*;

    // register shadow, updated from observed APB writes
    logic [MAC_W-1:0] dest_mac;
    logic [MAC_W-1:0] src_mac;
    logic [MAC_W-1:0] bss_mac;
    logic [SEQ_W-1:0] seq_num;
    logic             fcs_on;

    // frame state
    logic             frame_open;
    logic [10:0]      pay_count;
    logic [31:0]      crc_run;
    logic             dropped;

    out_item_t        frame_bytes_due[$];

    function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        logic        fb;
        r = c;
        for (int i = 0; i < 8; i++) begin
            fb = r[0] ^ b[i];
            r  = {1'b0, r[31:1]};
            if (fb) begin
                r = r ^ CRC_POLY;
            end
        end
        return r;
    endfunction

    task automatic clear_frame();
        frame_open = 1'b0;
        pay_count  = '0;
        crc_run    = CRC_INIT;
        dropped    = 1'b0;
    endtask

    task automatic push_byte(input logic [7:0] b, input logic add_crc);
        out_item_t e;
        e.frame_byte = b;
        e.frame_last = 1'b0;
        e.oversize   = dropped;
        frame_bytes_due.push_back(e);
        if (add_crc) begin
            crc_run = crc_step(crc_run, b);
        end
    endtask

    task automatic push_mac(input logic [MAC_W-1:0] mac);
        // most significant byte goes out first
        for (int i = 5; i >= 0; i--) begin
            push_byte(mac[8*i +: 8], 1'b1);
        end
    endtask

    task automatic predict_frame_bytes(input in_item_t it);
        logic        ending;
        int          emitted;
        logic [15:0] seq_ctrl;
        logic [31:0] fcs;
        out_item_t   tail;
        ending  = it.last_byte | it.empty_frame;
        emitted = 0;
        if (!frame_open) begin
            clear_frame();
            frame_open = 1'b1;
            seq_ctrl   = {seq_num, 4'h0};
            push_byte(FRAME_CTRL_LO, 1'b1);
            push_byte(FRAME_CTRL_HI, 1'b1);
            push_byte(DURATION[7:0], 1'b1);
            push_byte(DURATION[15:8], 1'b1);
            push_mac(dest_mac);
            push_mac(src_mac);
            push_mac(bss_mac);
            push_byte(seq_ctrl[7:0], 1'b1);
            push_byte(seq_ctrl[15:8], 1'b1);
            emitted = HDR_BYTES;
        end
        if (!it.empty_frame) begin
            if (pay_count < PAYLOAD_LIMIT) begin
                push_byte(it.payload_byte, 1'b1);
                pay_count = pay_count + 1'b1;
                emitted++;
            end else begin
                dropped = 1'b1;
            end
        end
        if (ending) begin
            if (fcs_on) begin
                fcs = ~crc_run;
                for (int k = 0; k < FCS_BYTES; k++) begin
                    push_byte(fcs[8*k +: 8], 1'b0);
                end
            end else if (emitted == 0) begin
                // nothing left to carry the end mark: a zero filler byte does
                push_byte(8'h00, 1'b0);
            end
            tail = frame_bytes_due.pop_back();
            tail.frame_last = 1'b1;
            frame_bytes_due.push_back(tail);
            clear_frame();
        end
    endtask

    task automatic report_field(input string name, input int want, input int got);
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            dest_mac       = '0;
            src_mac        = '0;
            bss_mac        = '0;
            seq_num        = '0;
            fcs_on         = 1'b1;
            mismatch_count = 0;
            clear_frame();
            frame_bytes_due.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[5:3])
                    REG_DEST:   dest_mac = pwdata[MAC_W-1:0];
                    REG_SOURCE: src_mac  = pwdata[MAC_W-1:0];
                    REG_BSS:    bss_mac  = pwdata[MAC_W-1:0];
                    REG_SEQ:    seq_num  = pwdata[SEQ_W-1:0];
                    REG_FCS:    fcs_on   = pwdata[0];
                    default: ;
                endcase
            end
            // check the output transfer first: it can only belong to earlier inputs
            if (m_valid && m_ready) begin
                if (frame_bytes_due.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %0h/%0b/%0b",
                             $time, m_data.frame_byte, m_data.frame_last, m_data.oversize);
                    mismatch_count++;
                end else begin
                    want = frame_bytes_due.pop_front();
                    if (m_data.frame_byte !== want.frame_byte)
                        report_field("frame_byte", int'(want.frame_byte),
                                     int'(m_data.frame_byte));
                    if (m_data.frame_last !== want.frame_last)
                        report_field("frame_last", int'(want.frame_last),
                                     int'(m_data.frame_last));
                    if (m_data.oversize !== want.oversize)
                        report_field("oversize", int'(want.oversize),
                                     int'(m_data.oversize));
                end
            end
            if (s_valid && s_ready) begin
                predict_frame_bytes(s_data);
            end
        end
        results_pending = frame_bytes_due.size();
    end

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
    import wdfb_pkg::*;

    localparam int PAYLOAD_LIMIT = 1500;
    localparam int CYCLE_LIMIT   = 800000;
    localparam int SETTLE_CYCLES = 40;

    typedef enum {END_LAST, END_EMPTY, END_BOTH} frame_end_t;

    logic              aclk    = 1'b0;
    logic              aresetn = 1'b0;

    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr   = '0;
    logic [DATA_W-1:0] pwdata  = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    logic              s_valid = 1'b0;
    logic              s_ready;
    in_item_t          s_data  = '0;

    logic              m_valid;
    logic              m_ready = 1'b0;
    out_item_t         m_data;

    int                mismatch_count;
    int                results_pending;
    int                cycle_count = 0;
    int                items_sent  = 0;
    bit                quiet       = 1'b0;
    int                stall_left  = 0;
    int                calm_left   = 0;

    always #6 aclk = ~aclk;

    wlan_data_frame_builder_core #(
        .MAX_PAYLOAD(PAYLOAD_LIMIT)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    wdfb_frame_checker #(
        .PAYLOAD_LIMIT(PAYLOAD_LIMIT)
    ) chk (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending)
    );

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // receiver back-pressure: short stall bursts, with calm stretches
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else if (quiet || calm_left > 0) begin
            m_ready <= 1'b1;
            if (calm_left > 0) calm_left--;
        end else if ($urandom_range(0, 49) == 0) begin
            calm_left = $urandom_range(20, 120);
            m_ready <= 1'b1;
        end else if ($urandom_range(0, 4) == 0) begin
            m_ready <= 1'b0;
            stall_left = $urandom_range(0, 7);
        end else begin
            m_ready <= 1'b1;
        end
    end

    function automatic logic [MAC_W-1:0] rand_mac();
        return MAC_W'({$urandom, $urandom});
    endfunction

    // called at a rising edge; returns at the edge that completes the transfer
    task automatic send_item(input in_item_t it);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(negedge aclk);
        while (!s_ready) @(negedge aclk);
        @(posedge aclk);
        items_sent++;
    endtask

    task automatic send_frame(input int len, input frame_end_t how);
        in_item_t it;
        for (int k = 0; k < len; k++) begin
            it.payload_byte = 8'($urandom_range(0, 255));
            it.last_byte    = (how == END_LAST) && (k == len - 1);
            it.empty_frame  = 1'b0;
            send_item(it);
        end
        if (how != END_LAST) begin
            it.payload_byte = 8'($urandom_range(0, 255));
            it.last_byte    = (how == END_BOTH);
            it.empty_frame  = 1'b1;
            send_item(it);
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (results_pending != 0) @(negedge aclk);
        @(posedge aclk);
    endtask

    // drained, plus room for a dropped byte still being consumed
    task automatic settle();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic reg_write(input logic [2:0] idx, input logic [DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        while (!pready) @(negedge aclk);
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_config(input logic [MAC_W-1:0] dest, src, bss,
                              input logic [SEQ_W-1:0] seq, input logic fcs);
        settle();
        reg_write(REG_DEST,   DATA_W'(dest));
        reg_write(REG_SOURCE, DATA_W'(src));
        reg_write(REG_BSS,    DATA_W'(bss));
        reg_write(REG_SEQ,    DATA_W'(seq));
        reg_write(REG_FCS,    DATA_W'(fcs));
    endtask

    function automatic int short_len();
        if ($urandom_range(0, 7) == 0) return $urandom_range(1, 64);
        return $urandom_range(1, 12);
    endfunction

    initial begin
        int       section_end;
        int       pick;
        in_item_t junk;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: field extremes and frame endings with FCS on
        set_config(48'h0123_4567_89AB, '1, '0, 12'hFFF, 1'b1);
        send_item('{8'h00, 1'b0, 1'b0});
        send_item('{8'hFF, 1'b0, 1'b0});
        send_item('{8'h5A, 1'b0, 1'b0});
        send_item('{8'hA5, 1'b1, 1'b0});
        send_item('{8'h3C, 1'b0, 1'b1});   // empty frame: header + FCS
        send_item('{8'h81, 1'b1, 1'b0});   // one-byte frame
        send_item('{8'h12, 1'b0, 1'b0});
        send_item('{8'hEE, 1'b0, 1'b1});   // ended by empty mid-frame
        send_item('{8'h7F, 1'b1, 1'b1});   // last and empty together

        // same with FCS off
        set_config('1, '0, 48'hA5A5_5A5A_C3C3, '0, 1'b0);
        send_item('{8'hC3, 1'b0, 1'b1});   // header only, last mark on its final byte
        send_item('{8'h01, 1'b0, 1'b0});
        send_item('{8'hFE, 1'b1, 1'b0});
        send_item('{8'h55, 1'b0, 1'b0});
        send_item('{8'hAA, 1'b0, 1'b0});
        send_item('{8'h99, 1'b0, 1'b1});   // no byte on the ending transfer: filler
        send_item('{8'h80, 1'b1, 1'b0});
        send_item('{8'h66, 1'b0, 1'b0});
        send_item('{8'h24, 1'b1, 1'b1});

        // random traffic in sections with different register settings
        for (int sec = 0; sec < 4; sec++) begin
            case (sec)
                0: set_config('0, '0, '0, '0, 1'b1);
                1: set_config('1, '1, '1, '1, 1'b0);
                2: set_config(rand_mac(), rand_mac(), rand_mac(),
                              SEQ_W'($urandom_range(0, 4095)), 1'($urandom_range(0, 1)));
                default: begin
                    quiet = 1'b1;
                    set_config(rand_mac(), rand_mac(), rand_mac(),
                               SEQ_W'($urandom_range(0, 4095)), 1'b1);
                end
            endcase
            section_end = items_sent + 72;
            while (items_sent < section_end) begin
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    send_frame(short_len(), END_LAST);
                end else if (pick < 78) begin
                    send_frame(short_len(), END_EMPTY);
                end else if (pick < 84) begin
                    send_frame(short_len(), END_BOTH);
                end else if (pick < 90) begin
                    send_frame(0, $urandom_range(0, 1) ? END_EMPTY : END_BOTH);
                end else begin
                    // loose items with random flags, then close the frame
                    repeat ($urandom_range(1, 6)) begin
                        junk = 10'($urandom_range(0, 1023));
                        send_item(junk);
                    end
                    send_item('{8'($urandom_range(0, 255)), 1'b1, 1'b0});
                end
                if (!quiet && $urandom_range(0, 29) == 0) begin
                    wait_drained();
                end
            end
        end

        settle();
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
